### sv/spmt_pkg.sv
package spmt_pkg;

    localparam int VADDR_W    = 15;
    localparam int COUNT_W    = 16;
    localparam int ADDR_W     = 20;
    localparam int BASE_W     = 10;
    localparam int SIZE_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    // Page index width covering the largest supported map of 64 pages.
    localparam int PIDX_W     = 6;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_BASE_PAGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE_PAGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_PAGES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_PAGES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_PAGES     = 3'd4;

    typedef struct packed {
        logic [BASE_W-1:0] text_base_page;
        logic [BASE_W-1:0] image_base_page;
        logic [SIZE_W-1:0] text_pages;
        logic [SIZE_W-1:0] data_pages;
        logic [SIZE_W-1:0] stack_pages;
    } cfg_t;

    typedef struct packed {
        logic [VADDR_W-1:0] vaddr;
        logic [PIDX_W-1:0]  first_page;
        logic [PIDX_W-1:0]  last_page;
        logic               first_in_map;
        logic               nonempty;
        logic               fits;
    } job_t;

endpackage

### sv/segment_page_map_translator.sv
// Translates a virtual word address and word count through a page map that is
// derived on the fly from five segment registers (text, data after the u-area,
// and stack pages, with stack winning on overlap). Each transfer on the input
// side yields one result transfer with the physical address of the first word,
// whether the whole range is mapped, and the range's physical address when its
// pages are physically contiguous. The back end walks the pages the range spans
// (up to NUM_PAGES) one per cycle through a single page lookup; empty ranges
// and ranges that run past the map skip the walk. A two-entry queue between
// the input side and the page walker lets new queries be taken while a result
// waits on the output. Configuration registers must only be written while no
// query is in flight.
module segment_page_map_translator #(
    parameter int NUM_PAGES        = 32,
    parameter int PAGE_SHIFT       = 10,
    parameter int STACK_FIRST_PAGE = 24,
    parameter int UAREA_PAGES      = 1,
    parameter int PHYS_PAGE_BITS   = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [spmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spmt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [spmt_pkg::VADDR_W-1:0]       vaddr,
    input  logic [spmt_pkg::COUNT_W-1:0]       count,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [spmt_pkg::ADDR_W-1:0]        phys_addr,
    output logic                               range_mapped,
    output logic [spmt_pkg::ADDR_W-1:0]        contig_addr
);

    spmt_pkg::cfg_t cfg_reg;
    spmt_pkg::cfg_t cfg_next;
    spmt_pkg::job_t front_job;
    spmt_pkg::job_t back_job;
    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                spmt_pkg::REG_TEXT_BASE_PAGE:
                begin
                    cfg_next.text_base_page = cfg_data[spmt_pkg::BASE_W-1:0];
                end
                spmt_pkg::REG_IMAGE_BASE_PAGE:
                begin
                    cfg_next.image_base_page = cfg_data[spmt_pkg::BASE_W-1:0];
                end
                spmt_pkg::REG_TEXT_PAGES:
                begin
                    cfg_next.text_pages = cfg_data[spmt_pkg::SIZE_W-1:0];
                end
                spmt_pkg::REG_DATA_PAGES:
                begin
                    cfg_next.data_pages = cfg_data[spmt_pkg::SIZE_W-1:0];
                end
                spmt_pkg::REG_STACK_PAGES:
                begin
                    cfg_next.stack_pages = cfg_data[spmt_pkg::SIZE_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spmt_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .vaddr     (vaddr),
        .count     (count),
        .fifo_full (fifo_full),
        .push      (push),
        .job       (front_job)
    );

    spmt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (front_job),
        .full     (fifo_full),
        .pop      (pop),
        .empty    (fifo_empty),
        .data_out (back_job)
    );

    spmt_back #(
        .PAGE_SHIFT       (PAGE_SHIFT),
        .STACK_FIRST_PAGE (STACK_FIRST_PAGE),
        .UAREA_PAGES      (UAREA_PAGES),
        .PHYS_PAGE_BITS   (PHYS_PAGE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fifo_empty   (fifo_empty),
        .job          (back_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .phys_addr    (phys_addr),
        .range_mapped (range_mapped),
        .contig_addr  (contig_addr)
    );

endmodule

### sv/spmt_front.sv
module spmt_front #(
    parameter int NUM_PAGES  = 32,
    parameter int PAGE_SHIFT = 10
) (
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [spmt_pkg::VADDR_W-1:0]   vaddr,
    input  logic [spmt_pkg::COUNT_W-1:0]   count,
    input  logic                           fifo_full,
    output logic                           push,
    output spmt_pkg::job_t                 job
);

    localparam int SUM_W   = spmt_pkg::COUNT_W + 1;
    localparam int LIMIT_W = PAGE_SHIFT + 7;
    localparam int CMP_W   = (LIMIT_W > SUM_W) ? LIMIT_W : SUM_W;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(NUM_PAGES) << PAGE_SHIFT;

    logic [SUM_W-1:0] end_addr;
    logic [SUM_W-1:0] last_addr;
    logic [SUM_W-1:0] first_full;
    logic [SUM_W-1:0] last_full;

    assign end_addr   = SUM_W'(vaddr) + SUM_W'(count);
    assign last_addr  = end_addr - SUM_W'(1);
    assign first_full = SUM_W'(vaddr) >> PAGE_SHIFT;
    assign last_full  = last_addr >> PAGE_SHIFT;

    always_comb
    begin
        job.vaddr        = vaddr;
        job.first_page   = first_full[spmt_pkg::PIDX_W-1:0];
        job.last_page    = last_full[spmt_pkg::PIDX_W-1:0];
        job.first_in_map = first_full < SUM_W'(NUM_PAGES);
        job.nonempty     = count != '0;
        job.fits         = CMP_W'(end_addr) <= LIMIT;
    end

    assign in_stall = fifo_full;
    assign push     = in_valid && !fifo_full;

endmodule

### sv/spmt_fifo.sv
module spmt_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  spmt_pkg::job_t data_in,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output spmt_pkg::job_t data_out
);

    localparam int DEPTH  = spmt_pkg::FIFO_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    spmt_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign data_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### sv/spmt_back.sv
module spmt_back #(
    parameter int PAGE_SHIFT       = 10,
    parameter int STACK_FIRST_PAGE = 24,
    parameter int UAREA_PAGES      = 1,
    parameter int PHYS_PAGE_BITS   = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spmt_pkg::cfg_t                cfg,
    input  logic                          fifo_empty,
    input  spmt_pkg::job_t                job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [spmt_pkg::ADDR_W-1:0]   phys_addr,
    output logic                          range_mapped,
    output logic [spmt_pkg::ADDR_W-1:0]   contig_addr
);

    localparam int PIDX_W = spmt_pkg::PIDX_W;
    localparam int ADDR_W = spmt_pkg::ADDR_W;
    localparam int VA_W   = spmt_pkg::VADDR_W;
    localparam int SUM_W  = 18;
    localparam int FULL_W = PHYS_PAGE_BITS + PAGE_SHIFT;
    localparam int EXP_W  = PHYS_PAGE_BITS + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_WALK = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    function automatic logic [PHYS_PAGE_BITS-1:0] page_entry(
        input spmt_pkg::cfg_t    c,
        input logic [PIDX_W-1:0] v
    );
        logic [PIDX_W:0] soff;
        logic [PIDX_W:0] doff;
        logic [SUM_W-1:0] dbase;
        logic [SUM_W-1:0] sum;
        logic in_stack;
        logic in_data;
        logic in_text;
        soff     = {1'b0, v} - (PIDX_W+1)'(STACK_FIRST_PAGE);
        doff     = {1'b0, v} - {1'b0, c.text_pages};
        in_stack = ({1'b0, v} >= (PIDX_W+1)'(STACK_FIRST_PAGE))
                   && (soff < {1'b0, c.stack_pages});
        in_data  = (v >= c.text_pages) && (doff < {1'b0, c.data_pages});
        in_text  = v < c.text_pages;
        dbase    = SUM_W'(c.image_base_page) + SUM_W'(UAREA_PAGES);
        if (in_stack)
        begin
            sum = dbase + SUM_W'(c.data_pages) + SUM_W'(soff);
        end
        else if (in_data)
        begin
            sum = dbase + SUM_W'(doff);
        end
        else if (in_text)
        begin
            sum = SUM_W'(c.text_base_page) + SUM_W'(v);
        end
        else
        begin
            sum = '0;
        end
        return sum[PHYS_PAGE_BITS-1:0];
    endfunction

    state_t                    state_reg;
    state_t                    state_next;
    spmt_pkg::job_t            job_reg;
    spmt_pkg::job_t            job_next;
    logic [PIDX_W-1:0]         v_reg;
    logic [PIDX_W-1:0]         v_next;
    logic [PIDX_W-1:0]         off_reg;
    logic [PIDX_W-1:0]         off_next;
    logic [PHYS_PAGE_BITS-1:0] ppn_reg;
    logic [PHYS_PAGE_BITS-1:0] ppn_next;
    logic                      mapped_reg;
    logic                      mapped_next;
    logic                      contig_reg;
    logic                      contig_next;

    logic [PHYS_PAGE_BITS-1:0] entry;
    logic [EXP_W-1:0]          expected;
    logic [VA_W+PAGE_SHIFT-1:0] va_ext;
    logic [ADDR_W+FULL_W-1:0]  phys_wide;
    logic [ADDR_W-1:0]         phys;

    assign entry     = page_entry(cfg, v_reg);
    assign expected  = EXP_W'(ppn_reg) + EXP_W'(off_reg);
    assign va_ext    = {{PAGE_SHIFT{1'b0}}, job_reg.vaddr};
    assign phys_wide = {{ADDR_W{1'b0}}, ppn_reg, va_ext[PAGE_SHIFT-1:0]};
    assign phys      = (ppn_reg == '0) ? '0 : phys_wide[ADDR_W-1:0];

    assign out_valid    = state_reg == ST_OUT;
    assign phys_addr    = phys;
    assign range_mapped = mapped_reg;
    assign contig_addr  = (job_reg.nonempty && mapped_reg && contig_reg) ? phys : '0;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        v_next      = v_reg;
        off_next    = off_reg;
        ppn_next    = ppn_reg;
        mapped_next = mapped_reg;
        contig_next = contig_reg;
        pop         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop         = 1'b1;
                    job_next    = job;
                    v_next      = job.first_page;
                    off_next    = '0;
                    mapped_next = 1'b1;
                    contig_next = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ppn_next = job_reg.first_in_map ? entry : '0;
                if (job_reg.nonempty && job_reg.fits)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    mapped_next = !job_reg.nonempty;
                    state_next  = ST_OUT;
                end
            end
            ST_WALK:
            begin
                if (entry == '0)
                begin
                    mapped_next = 1'b0;
                end
                if ({1'b0, entry} != expected)
                begin
                    contig_next = 1'b0;
                end
                if (v_reg == job_reg.last_page)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    v_next   = v_reg + PIDX_W'(1);
                    off_next = off_reg + PIDX_W'(1);
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        v_reg      <= v_next;
        off_reg    <= off_next;
        ppn_reg    <= ppn_next;
        mapped_reg <= mapped_next;
        contig_reg <= contig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_contig_implies_mapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && contig_addr != '0 |-> range_mapped && contig_addr == phys_addr)
        else $error("contiguous address given for an unmapped range");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> v_reg <= job_reg.last_page)
        else $error("page walk ran past the last page");

    a_walk_offset: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> v_reg == job_reg.first_page + off_reg)
        else $error("page walk offset out of step with page index");

    a_walk_only_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> job_reg.nonempty && job_reg.fits)
        else $error("page walk started for an empty or oversized range");

    a_unmapped_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !range_mapped |-> job_reg.nonempty)
        else $error("empty range reported as unmapped");
`endif

endmodule
